@@ sv/rtq_pkg.sv @@
package rtq_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam int OCC_W = $clog2(NUM_ENTRIES + 1);
   localparam int KEY_W = 48;

   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   // opcodes
   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_ACK  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   // result status codes
   localparam logic [3:0] ST_ADDED     = 4'd0;
   localparam logic [3:0] ST_FULL      = 4'd1;
   localparam logic [3:0] ST_DUP       = 4'd2;
   localparam logic [3:0] ST_ACKED     = 4'd3;
   localparam logic [3:0] ST_UNKNOWN   = 4'd4;
   localparam logic [3:0] ST_AMBIGUOUS = 4'd5;
   localparam logic [3:0] ST_RESEND    = 4'd6;
   localparam logic [3:0] ST_TIMEOUT   = 4'd7;
   localparam logic [3:0] ST_DONE      = 4'd8;

   // register indexes
   localparam logic [1:0] REG_INIT_DELAY = 2'd0;
   localparam logic [1:0] REG_MAX_DELAY  = 2'd1;
   localparam logic [1:0] REG_TIMEOUT    = 2'd2;
   localparam logic [1:0] REG_SPARE      = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] packet_id;
      logic [31:0] generation_id;
      logic [15:0] packet_handle;
      logic [47:0] time_now;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] out_handle;
      logic [15:0] out_packet_id;
      logic [47:0] first_sent_time;
      logic        was_retransmitted;
      logic        last;
      logic [OCC_W-1:0] occupancy;
      logic        id_pending;
      logic [47:0] next_deadline;
      logic        deadline_valid;
   } rsp_type;

   function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? TIME_MAX : s[47:0];
   endfunction

endpackage

@@ sv/rtq_front.sv @@
// Front end: register accepted words into a two-entry queue.
module rtq_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rtq_pkg::req_type req_data,
   output logic            cmd_valid,
   input  logic            cmd_ready,
   output rtq_pkg::req_type cmd_data
);
   import rtq_pkg::*;

   req_type   q_ff [2];
   req_type   q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   // unused opcode is dropped at the door
   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready && (req_data.opcode != OP_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[0];
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = req_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end
endmodule

@@ sv/rtq_back.sv @@
// Back end: entry table, sequencer for add, ack and tick sweep.
module rtq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  rtq_pkg::req_type cmd_data,
   input  logic [23:0]      init_delay,
   input  logic [23:0]      max_delay,
   input  logic [23:0]      timeout,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rtq_pkg::rsp_type rsp_data
);
   import rtq_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SEL   = 3'd2;
   localparam logic [2:0] S_VISIT = 3'd3;
   localparam logic [2:0] S_DL    = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [NUM_ENTRIES-1:0] vld_ff, vld_in;
   logic [15:0] id_ff   [NUM_ENTRIES];
   logic [31:0] gen_ff  [NUM_ENTRIES];
   logic [15:0] hdl_ff  [NUM_ENTRIES];
   logic [47:0] fst_ff  [NUM_ENTRIES];
   logic [47:0] nrt_ff  [NUM_ENTRIES];
   logic [23:0] dly_ff  [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] rs_ff;

   logic [2:0]  st_ff, st_in;
   req_type     cur_ff, cur_in;
   logic        pend_ff, pend_in;
   logic [47:0] prev_ff, prev_in;
   logic        hprev_ff, hprev_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic        sel_ok_ff, sel_ok_in;
   logic [IDX_W-1:0] sel_ff, sel_in;
   logic [47:0] skey_ff, skey_in;
   logic [47:0] best_ff, best_in;
   logic        hbest_ff, hbest_in;
   logic        ptrend;
   rsp_type     out_ff, out_in;
   logic        ov_ff, ov_in;
   rsp_type     fin_ff, fin_in;   // final word of the item

   // resent entries of a sweep, in key order, replayed after the deadline pass
   logic [IDX_W-1:0] rl_ff [NUM_ENTRIES];
   logic [OCC_W-1:0] rcnt_ff, rcnt_in;
   logic [OCC_W-1:0] eptr_ff, eptr_in;
   logic [IDX_W-1:0] ridx;

   // entry write strobes
   logic        wr_add, wr_rs;
   logic [IDX_W-1:0] wr_idx;
   logic [47:0] rs_next;
   logic [23:0] rs_dly;

   // combinational match / free search (16 independent compares)
   logic [NUM_ENTRIES-1:0] match;
   logic [OCC_W-1:0] occ, nmatch;
   logic        have_free, have_hit;
   logic [IDX_W-1:0] free_idx, hit_idx;

   always_comb begin
      occ = '0; nmatch = '0; have_free = 1'b0; have_hit = 1'b0;
      free_idx = '0; hit_idx = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         match[i] = vld_ff[i] && (id_ff[i] == cur_ff.packet_id);
         if (vld_ff[i]) occ = occ + 1'b1;
         if (match[i]) nmatch = nmatch + 1'b1;
         if (!vld_ff[i] && !have_free) begin
            have_free = 1'b1; free_idx = IDX_W'(i);
         end
         if (match[i] && !have_hit) begin
            have_hit = 1'b1; hit_idx = IDX_W'(i);
         end
      end
   end

   // per-entry data at the scan pointer and at the selected entry
   logic [47:0] pkey, pto, pdl, sto;
   logic [24:0] dbl;
   assign pkey = {gen_ff[ptr_ff], id_ff[ptr_ff]};
   assign pto  = sat_add(fst_ff[ptr_ff], {24'd0, timeout});
   assign pdl  = (nrt_ff[ptr_ff] < pto) ? nrt_ff[ptr_ff] : pto;
   assign sto  = sat_add(fst_ff[sel_ff], {24'd0, timeout});
   assign dbl  = {dly_ff[sel_ff], 1'b0};
   assign ptrend = (ptr_ff == IDX_W'(NUM_ENTRIES - 1));
   assign ridx = rl_ff[eptr_ff[IDX_W-1:0]];

   assign cmd_ready = (st_ff == S_IDLE) && !ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      st_in = st_ff; cur_in = cur_ff; pend_in = pend_ff;
      prev_in = prev_ff; hprev_in = hprev_ff; ptr_in = ptr_ff;
      sel_ok_in = sel_ok_ff; sel_in = sel_ff; skey_in = skey_ff;
      best_in = best_ff; hbest_in = hbest_ff;
      out_in = out_ff; ov_in = ov_ff; fin_in = fin_ff;
      rcnt_in = rcnt_ff; eptr_in = eptr_ff;
      vld_in = vld_ff;
      wr_add = 1'b0; wr_rs = 1'b0; wr_idx = '0;
      rs_next = '0; rs_dly = '0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (cmd_valid && !ov_ff) begin
               cur_in = cmd_data;
               st_in  = S_SCAN;
            end
         end
         // classify against the table
         S_SCAN: begin
            pend_in = (nmatch != '0);
            fin_in  = '0;
            fin_in.out_packet_id = cur_ff.packet_id;
            fin_in.last = 1'b1;
            st_in = S_DL;
            case (cur_ff.opcode)
               OP_ADD: begin
                  if (!have_free) fin_in.status = ST_FULL;
                  else if (nmatch != '0) fin_in.status = ST_DUP;
                  else begin
                     fin_in.status = ST_ADDED;
                     wr_add = 1'b1; wr_idx = free_idx;
                     vld_in[free_idx] = 1'b1;
                  end
               end
               OP_ACK: begin
                  if (nmatch == '0) fin_in.status = ST_UNKNOWN;
                  else if (nmatch != OCC_W'(1)) fin_in.status = ST_AMBIGUOUS;
                  else begin
                     fin_in.status = ST_ACKED;
                     fin_in.out_handle = hdl_ff[hit_idx];
                     fin_in.first_sent_time = fst_ff[hit_idx];
                     fin_in.was_retransmitted = rs_ff[hit_idx];
                     vld_in[hit_idx] = 1'b0;
                  end
               end
               default: begin
                  hprev_in = 1'b0;
                  sel_ok_in = 1'b0;
                  st_in = S_SEL;
               end
            endcase
            ptr_in = '0; hbest_in = 1'b0; best_in = '0;
            rcnt_in = '0; eptr_in = '0;
         end
         // find next key above prev, one entry a cycle
         S_SEL: begin
            if (vld_ff[ptr_ff] && (!hprev_ff || pkey > prev_ff) &&
                (!sel_ok_ff || pkey < skey_ff)) begin
               sel_ok_in = 1'b1; sel_in = ptr_ff; skey_in = pkey;
            end
            ptr_in = ptr_ff + 1'b1;
            if (ptrend) st_in = S_VISIT;
         end
         // act on the selected entry; resends are only recorded here
         S_VISIT: begin
            if (!sel_ok_ff) begin
               fin_in = '0; fin_in.status = ST_DONE; fin_in.last = 1'b1;
               ptr_in = '0; st_in = S_DL;
            end else if (cur_ff.time_now >= sto) begin
               fin_in = '0; fin_in.status = ST_TIMEOUT;
               fin_in.out_handle = hdl_ff[sel_ff];
               fin_in.out_packet_id = id_ff[sel_ff];
               fin_in.last = 1'b1;
               ptr_in = '0; st_in = S_DL;
            end else begin
               if (cur_ff.time_now >= nrt_ff[sel_ff]) begin
                  rs_dly = (dbl > {1'b0, max_delay}) ? max_delay : dbl[23:0];
                  rs_next = sat_add(cur_ff.time_now, {24'd0, rs_dly});
                  wr_rs = 1'b1; wr_idx = sel_ff;
                  rcnt_in = rcnt_ff + 1'b1;
               end
               st_in = S_SEL;
               prev_in = skey_ff; hprev_in = 1'b1; sel_ok_in = 1'b0; ptr_in = '0;
            end
         end
         // earliest deadline, one entry a cycle
         S_DL: begin
            if (vld_ff[ptr_ff] && (!hbest_ff || pdl < best_ff)) begin
               best_in = pdl; hbest_in = 1'b1;
            end
            ptr_in = ptr_ff + 1'b1;
            if (ptrend) st_in = S_EMIT;
         end
         // recorded resend words first, then the final word
         S_EMIT: begin
            if (!ov_ff || rsp_ready) begin
               if (eptr_ff != rcnt_ff) begin
                  out_in = '0; out_in.status = ST_RESEND;
                  out_in.out_handle = hdl_ff[ridx];
                  out_in.out_packet_id = id_ff[ridx];
                  eptr_in = eptr_ff + 1'b1;
               end else begin
                  out_in = fin_ff;
                  st_in = S_IDLE;
               end
               out_in.occupancy = occ;
               out_in.id_pending = pend_ff;
               out_in.next_deadline = hbest_ff ? best_ff : '0;
               out_in.deadline_valid = hbest_ff;
               ov_in = 1'b1;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0; vld_ff <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; vld_ff <= vld_in;
      end
      cur_ff <= cur_in; pend_ff <= pend_in; prev_ff <= prev_in;
      hprev_ff <= hprev_in; ptr_ff <= ptr_in; sel_ok_ff <= sel_ok_in;
      sel_ff <= sel_in; skey_ff <= skey_in; best_ff <= best_in;
      hbest_ff <= hbest_in; out_ff <= out_in; fin_ff <= fin_in;
      rcnt_ff <= rcnt_in; eptr_ff <= eptr_in;
      if (wr_add) begin
         id_ff[wr_idx]  <= cur_ff.packet_id;
         gen_ff[wr_idx] <= cur_ff.generation_id;
         hdl_ff[wr_idx] <= cur_ff.packet_handle;
         fst_ff[wr_idx] <= cur_ff.time_now;
         dly_ff[wr_idx] <= init_delay;
         nrt_ff[wr_idx] <= sat_add(cur_ff.time_now, {24'd0, init_delay});
         rs_ff[wr_idx]  <= 1'b0;
      end
      if (wr_rs) begin
         dly_ff[wr_idx] <= rs_dly;
         nrt_ff[wr_idx] <= rs_next;
         rs_ff[wr_idx]  <= 1'b1;
         rl_ff[rcnt_ff[IDX_W-1:0]] <= sel_ff;
      end
   end
endmodule

@@ sv/retransmit_queue_with_backoff_top.sv @@
// Retransmit queue, 16 entries, one item at a time. An add or ack word passes
// the front queue, a classify step, a pass over the table for the earliest
// deadline and then emit before its result word. A tick sweep runs, for each
// entry in key order, a selection pass over the table and a visit, then one
// more selection pass that finds no further entry (or stops at a timeout),
// then the deadline pass. Resend words are then given one a cycle while the
// receiver is ready, followed by the sweep done or timeout word; all words of
// a sweep carry the occupancy and deadline of the table after the sweep. The
// next item enters once the final word of the previous one has been taken.
module retransmit_queue_with_backoff_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rtq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rtq_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_data
);
   import rtq_pkg::*;

   logic [23:0] init_ff, max_ff, tmo_ff;
   logic        cmd_valid, cmd_ready;
   req_type     cmd_data;

   // config registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 24'd100; max_ff <= 24'd2000; tmo_ff <= 24'd10000;
      end else if (csr_valid) begin
         case (csr_index)
            REG_INIT_DELAY: init_ff <= csr_data;
            REG_MAX_DELAY:  max_ff  <= csr_data;
            REG_TIMEOUT:    tmo_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   rtq_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   rtq_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .init_delay(init_ff), .max_delay(max_ff), .timeout(tmo_ff),
      .rsp_valid, .rsp_ready, .rsp_data
   );

`ifndef NO_ASSERTIONS
   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_RESEND |-> !rsp_data.last)
      else $error("resend word marked last");
   a_dl_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.deadline_valid == (rsp_data.occupancy != '0)))
      else $error("deadline valid disagrees with occupancy");
`endif
endmodule

@@ bench/testbench.sv @@
module testbench;
   import rtq_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0]  csr_index;
   logic [23:0] csr_data;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 400;

   retransmit_queue_with_backoff_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // queue state as the block should hold it
   logic [23:0] cfg_init_delay, cfg_max_delay, cfg_timeout;
   logic        tbl_valid   [NUM_ENTRIES];
   logic [15:0] tbl_id      [NUM_ENTRIES];
   logic [31:0] tbl_gen     [NUM_ENTRIES];
   logic [15:0] tbl_handle  [NUM_ENTRIES];
   logic [47:0] tbl_first   [NUM_ENTRIES];
   logic [47:0] tbl_retry   [NUM_ENTRIES];
   logic [23:0] tbl_delay   [NUM_ENTRIES];
   logic        tbl_resent  [NUM_ENTRIES];

   req_type pending_cmds[$];
   rsp_type expected_words[$];
   int      errors;
   bit      calm;

   function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? TIME_MAX : s[47:0];
   endfunction

   function automatic rsp_type make_word(logic [3:0] st, logic [15:0] h, logic [15:0] id,
                                         logic [47:0] first, logic resent, logic lst);
      rsp_type w;
      w = '0;
      w.status = st;
      w.out_handle = h;
      w.out_packet_id = id;
      w.first_sent_time = first;
      w.was_retransmitted = resent;
      w.last = lst;
      return w;
   endfunction

   // apply one command to the table, queue up the words it should produce
   task automatic queue_step(input req_type r);
      rsp_type     words[$];
      int          occ, match_cnt, hit, free_slot, sel;
      logic        was_pending, have_prev, stopped, have_best;
      logic [47:0] prev_key, sel_key, key, best, t, dl;
      logic [24:0] d;
      occ = 0; match_cnt = 0; hit = -1; free_slot = -1;
      if (r.opcode == OP_NONE) return;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (tbl_valid[i]) begin
            if (tbl_id[i] == r.packet_id) begin
               match_cnt++;
               if (hit < 0) hit = i;
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      was_pending = match_cnt > 0;
      case (r.opcode)
         OP_ADD: begin
            if (free_slot < 0) begin
               words = {words, make_word(ST_FULL, 16'd0, r.packet_id, 48'd0, 1'b0, 1'b1)};
            end else if (was_pending) begin
               words = {words, make_word(ST_DUP, 16'd0, r.packet_id, 48'd0, 1'b0, 1'b1)};
            end else begin
               tbl_valid[free_slot]  = 1'b1;
               tbl_id[free_slot]     = r.packet_id;
               tbl_gen[free_slot]    = r.generation_id;
               tbl_handle[free_slot] = r.packet_handle;
               tbl_first[free_slot]  = r.time_now;
               tbl_delay[free_slot]  = cfg_init_delay;
               tbl_retry[free_slot]  = add_sat48(r.time_now, {24'd0, cfg_init_delay});
               tbl_resent[free_slot] = 1'b0;
               words = {words, make_word(ST_ADDED, 16'd0, r.packet_id, 48'd0, 1'b0, 1'b1)};
            end
         end
         OP_ACK: begin
            if (match_cnt == 0) begin
               words = {words, make_word(ST_UNKNOWN, 16'd0, r.packet_id, 48'd0, 1'b0, 1'b1)};
            end else if (match_cnt > 1) begin
               words = {words,
                        make_word(ST_AMBIGUOUS, 16'd0, r.packet_id, 48'd0, 1'b0, 1'b1)};
            end else begin
               words = {words, make_word(ST_ACKED, tbl_handle[hit], r.packet_id,
                                         tbl_first[hit], tbl_resent[hit], 1'b1)};
               tbl_valid[hit] = 1'b0;
            end
         end
         default: begin
            // sweep in ascending {generation, id} order
            have_prev = 1'b0; stopped = 1'b0; prev_key = '0;
            for (int k = 0; k < NUM_ENTRIES && !stopped; k++) begin
               sel = -1; sel_key = '0;
               for (int i = 0; i < NUM_ENTRIES; i++) begin
                  if (!tbl_valid[i]) continue;
                  key = {tbl_gen[i], tbl_id[i]};
                  if (have_prev && key <= prev_key) continue;
                  if (sel < 0 || key < sel_key) begin
                     sel = i;
                     sel_key = key;
                  end
               end
               if (sel < 0) break;
               prev_key = sel_key;
               have_prev = 1'b1;
               if (r.time_now >= add_sat48(tbl_first[sel], {24'd0, cfg_timeout})) begin
                  words = {words, make_word(ST_TIMEOUT, tbl_handle[sel], tbl_id[sel],
                                            48'd0, 1'b0, 1'b1)};
                  stopped = 1'b1;
               end else if (r.time_now >= tbl_retry[sel]) begin
                  d = {tbl_delay[sel], 1'b0};
                  if (d > {1'b0, cfg_max_delay}) d = {1'b0, cfg_max_delay};
                  words = {words, make_word(ST_RESEND, tbl_handle[sel], tbl_id[sel],
                                            48'd0, 1'b0, 1'b0)};
                  tbl_resent[sel] = 1'b1;
                  tbl_delay[sel]  = d[23:0];
                  tbl_retry[sel]  = add_sat48(r.time_now, {23'd0, d});
               end
            end
            if (!stopped)
               words = {words, make_word(ST_DONE, 16'd0, 16'd0, 48'd0, 1'b0, 1'b1)};
         end
      endcase
      // status fields reflect the table after the step
      occ = 0; have_best = 1'b0; best = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (!tbl_valid[i]) continue;
         occ++;
         t  = add_sat48(tbl_first[i], {24'd0, cfg_timeout});
         dl = tbl_retry[i] < t ? tbl_retry[i] : t;
         if (!have_best || dl < best) begin
            best = dl;
            have_best = 1'b1;
         end
      end
      foreach (words[k]) begin
         words[k].occupancy      = occ[OCC_W-1:0];
         words[k].id_pending     = was_pending;
         words[k].next_deadline  = have_best ? best : 48'd0;
         words[k].deadline_valid = have_best;
         expected_words = {expected_words, words[k]};
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // command driver
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) queue_step(req_data);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_data  <= pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_gap   <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random backpressure
   int rsp_stall;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected word: %h", rsp_data);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: st %0d/%0d h %h/%h id %h/%h first %h/%h rt %b/%b last %b/%b occ %0d/%0d pend %b/%b dl %h/%h dv %b/%b (exp/act)",
                        want.status, rsp_data.status, want.out_handle, rsp_data.out_handle,
                        want.out_packet_id, rsp_data.out_packet_id,
                        want.first_sent_time, rsp_data.first_sent_time,
                        want.was_retransmitted, rsp_data.was_retransmitted,
                        want.last, rsp_data.last, want.occupancy, rsp_data.occupancy,
                        want.id_pending, rsp_data.id_pending,
                        want.next_deadline, rsp_data.next_deadline,
                        want.deadline_valid, rsp_data.deadline_valid);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall <= pick_gap();
         end
      end
   end

   // watchdog on cycles without any handshake
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic push_cmd(logic [1:0] op, logic [15:0] id, logic [31:0] gen,
                           logic [15:0] h, logic [47:0] t);
      req_type r;
      r.opcode = op; r.packet_id = id; r.generation_id = gen;
      r.packet_handle = h; r.time_now = t;
      pending_cmds = {pending_cmds, r};
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_INIT_DELAY: cfg_init_delay = val;
         REG_MAX_DELAY:  cfg_max_delay  = val;
         REG_TIMEOUT:    cfg_timeout    = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // random traffic: mostly adds, acks and ticks over a small id pool
   task automatic random_phase(int count, logic [47:0] start, int step_max);
      logic [47:0] now;
      logic [15:0] id;
      int          r;
      now = start;
      for (int n = 0; n < count; n++) begin
         r  = $urandom_range(0, 99);
         id = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
         now = add_sat48(now, 48'($urandom_range(0, step_max)));
         if (r < 40)      push_cmd(OP_ADD, id, $urandom, 16'($urandom), now);
         else if (r < 68) push_cmd(OP_ACK, id, $urandom, 16'($urandom), now);
         else if (r < 98) push_cmd(OP_TICK, id, $urandom, 16'($urandom), now);
         else             push_cmd(OP_NONE, id, $urandom, 16'($urandom), now);
      end
      wait_idle();
   endtask

   initial begin
      errors = 0;
      calm = 1'b0;
      reset = 1'b1;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      cfg_init_delay = 24'd100; cfg_max_delay = 24'd2000; cfg_timeout = 24'd10000;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: fill, full before duplicate, acks, sweeps, timeout, unused opcode
      push_cmd(OP_ACK, 16'd5, 32'd0, 16'd0, 48'd0);
      for (int i = 0; i < NUM_ENTRIES; i++)
         push_cmd(OP_ADD, 16'(100 + i), (i == 3) ? 32'hFFFF_FFFF : 32'(i % 4),
                  (i == 0) ? 16'hFFFF : 16'(i), 48'(i));
      push_cmd(OP_ADD, 16'd116, 32'd0, 16'd0, 48'd20);
      push_cmd(OP_ADD, 16'd100, 32'd0, 16'd0, 48'd20);
      push_cmd(OP_ACK, 16'd100, 32'd0, 16'd0, 48'd30);
      push_cmd(OP_ADD, 16'd101, 32'd0, 16'd0, 48'd31);
      push_cmd(OP_TICK, 16'd101, 32'd0, 16'd0, 48'd110);
      push_cmd(OP_ACK, 16'd101, 32'd0, 16'd0, 48'd120);
      push_cmd(OP_TICK, 16'hFFFF, 32'd0, 16'd0, 48'd10005);
      push_cmd(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, TIME_MAX);
      wait_idle();
      random_phase(60, 48'd20000, 300);

      // smallest settings, unused index too
      csr_write(REG_INIT_DELAY, 24'd1);
      csr_write(REG_MAX_DELAY, 24'd1);
      csr_write(REG_TIMEOUT, 24'd1);
      csr_write(REG_SPARE, 24'hFFFFFF);
      random_phase(70, 48'd0, 2);

      // initial delay above cap
      calm = 1'b1;
      csr_write(REG_INIT_DELAY, 24'd500);
      csr_write(REG_MAX_DELAY, 24'd50);
      csr_write(REG_TIMEOUT, 24'd3000);
      random_phase(80, 48'd1000, 200);
      calm = 1'b0;

      // largest settings, times near saturation
      csr_write(REG_INIT_DELAY, 24'hFFFFFF);
      csr_write(REG_MAX_DELAY, 24'hFFFFFF);
      csr_write(REG_TIMEOUT, 24'hFFFFFF);
      random_phase(80, TIME_MAX - 48'h3FF_FFFF, 24'h7FFFFF);

      // random settings
      for (int p = 0; p < 2; p++) begin
         csr_write(REG_INIT_DELAY, 24'($urandom_range(1, 400)));
         csr_write(REG_MAX_DELAY, 24'($urandom_range(1, 3000)));
         csr_write(REG_TIMEOUT, 24'($urandom_range(200, 20000)));
         random_phase(75, {$urandom, 16'h0} >> 8, 500);
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
